@@ design/scv_pkg.sv @@
// Package: constants, types and the beat sine table of the chorus voice.
`default_nettype none
package scv_pkg;
    localparam int DelayDepth = 256;
    localparam int AddrBits   = 8;
    localparam int SineDepth  = 256;

    localparam logic signed [24:0] DlyMin     = 25'sd18748;
    localparam logic signed [24:0] DlyMax     = 25'sd60424;
    localparam logic signed [24:0] DlyCenter  = 25'sd39586;
    localparam logic signed [24:0] RightOfs   = 25'sd1536;
    localparam logic signed [17:0] PreCoef    = 18'sd30244;
    localparam logic signed [17:0] PostCoef   = 18'sd20676;
    localparam logic signed [31:0] KneeLevel  = 32'sd4096000;
    localparam logic signed [17:0] KneeSlope  = 18'sd9830;

    localparam logic [1:0] ModeOff = 2'd0;
    localparam logic [1:0] ModeBeat = 2'd3;

    localparam logic [1:0] RegMode   = 2'd0;
    localparam logic [1:0] RegBypass = 2'd1;
    localparam logic [1:0] RegRight  = 2'd2;

    typedef logic signed [15:0] t_sample;
    typedef logic [SineDepth-1:0][15:0] t_beat_table;

    // Per-mode phase step
    function automatic logic [31:0] phase_step(input logic [1:0] m);
        case (m)
            2'd1:    phase_step = 32'd48676;
            2'd2:    phase_step = 32'd77882;
            2'd3:    phase_step = 32'd63279;
            default: phase_step = 32'd0;
        endcase
    endfunction

    // Half range of the delay sweep per mode: floor(20838*depth/2^15)
    function automatic logic [14:0] sweep_half(input logic [1:0] m);
        case (m)
            2'd1:    sweep_half = 15'd13544;
            2'd2:    sweep_half = 15'd18754;
            2'd3:    sweep_half = 15'd16253;
            default: sweep_half = 15'd0;
        endcase
    endfunction

    // Polynomial sine in Q30, evaluated at elaboration for table entries
    function automatic longint sine_q30(input longint x);
        longint u, u2, r, s;
        logic neg;
        neg = x[31];
        u = x & 64'h7FFF_FFFF;
        if (u > 64'sd1073741824) u = 64'sd2147483648 - u;
        u2 = (u * u) >>> 30;
        r = 172272;
        r = 5026995 - ((u2 * r) >>> 30);
        r = 85569306 - ((u2 * r) >>> 30);
        r = 693598668 - ((u2 * r) >>> 30);
        r = 1686629713 - ((u2 * r) >>> 30);
        s = (u * r) >>> 30;
        sine_q30 = neg ? -s : s;
    endfunction

    // Beat term, round(9830*sin), entry k of the table
    function automatic logic signed [15:0] beat_entry(input logic [7:0] k);
        longint x, s, m, e;
        x = longint'(k) << 24;
        s = sine_q30(x);
        m = (s < 0) ? -s : s;
        e = (m * 9830 + 536870912) >>> 30;
        beat_entry = (s < 0) ? 16'(-e) : 16'(e);
    endfunction

    // Whole beat table, built once as a constant
    function automatic t_beat_table build_beat_table();
        t_beat_table tab;
        for (int k = 0; k < SineDepth; k++) tab[8'(k)] = beat_entry(8'(k));
        return tab;
    endfunction

    localparam t_beat_table BeatTable = build_beat_table();
endpackage
`default_nettype wire

@@ design/scv_if.sv @@
// Valid/ready stream interface carrying one audio sample.
`default_nettype none
interface scv_if;
    import scv_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ design/stereo_chorus_voice.sv @@
// Top level of the chorus voice: sequencer, delay memory, filters and knee.
`default_nettype none
// One chorus voice, fully wet. A sample transaction runs through a step
// sequencer that shares one multiplier; a new sample is accepted only in the
// idle step, and the span of the sequence is set by the dependent multiplies
// plus the two synchronous reads of the 256-entry delay memory. While a result
// waits in the output register the next sample is accepted and runs up to the
// knee step, where it holds until the output register is free. In bypass or
// mode 0 the sample goes through the pass step to the output register once it
// is free, with no state change. The delay memory is cleared by a pass over all
// 256 entries after reset, during which no sample is accepted; configuration
// writes are taken always.
module stereo_chorus_voice import scv_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    scv_if.sink        s_in,
    scv_if.source      m_out,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [3:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_PRE = 4'd2,
        S_WR = 4'd3, S_LFO = 4'd4, S_DLY = 4'd5, S_RD0 = 4'd6, S_RD1 = 4'd7,
        S_INT = 4'd8, S_POST = 4'd9, S_KNEE = 4'd10, S_OUT = 4'd11,
        S_PASS = 4'd12, S_SUM = 4'd13;

    logic [3:0] r_state, n_state;
    logic [1:0] r_mode;
    logic r_bypass, r_right;
    logic [AddrBits:0] r_clr;
    logic [AddrBits-1:0] r_widx;
    logic [31:0] r_phase;
    logic signed [24:0] r_pre, r_post;
    t_sample r_x, r_out;
    logic r_ovalid;

    logic signed [15:0] mem [DelayDepth];
    logic signed [15:0] r_rd;
    logic [AddrBits-1:0] r_i0;
    logic [7:0] r_frac;
    logic signed [15:0] r_s0;
    logic signed [31:0] r_acc;
    logic [16:0] r_lfo;
    logic [29:0] r_q;

    // Config port
    assign pready = 1'b1;
    logic [1:0] reg_idx;
    assign reg_idx = paddr[3:2];
    always_comb begin
        case (reg_idx)
            RegMode:   prdata = {30'd0, r_mode};
            RegBypass: prdata = {31'd0, r_bypass};
            RegRight:  prdata = {31'd0, r_right};
            default:   prdata = 32'd0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd1; r_bypass <= 1'b0; r_right <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                RegMode:   r_mode <= pwdata[1:0];
                RegBypass: r_bypass <= pwdata[0];
                RegRight:  r_right <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign s_in.ready = (r_state == S_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.sample = r_out;
    wire in_fire = s_in.valid && s_in.ready;
    // output register free for a new result at this edge
    wire out_free = !r_ovalid || m_out.ready;

    // LFO phase with channel offset, triangle
    logic [31:0] p;
    logic [16:0] tri_v;
    assign p = r_phase + (r_right ? 32'h8000_0000 : 32'd0);
    assign tri_v = p[31] ? 17'((33'h1_0000_0000 - {1'b0, p}) >> 15) : 17'(p >> 15);
    // angle floor(p*13/5) mod 2^32: q = p/5 by reciprocal (registered),
    // then 13*q plus floor(13*r/5) for the remainder r
    logic [63:0] q_prod;
    assign q_prod = 64'(p) * 64'hCCCC_CCCD;
    logic [2:0] p_rem;
    assign p_rem = 3'(p - 32'(r_q) * 32'd5);
    logic [3:0] rem_adj;
    always_comb begin
        case (p_rem)
            3'd1:    rem_adj = 4'd2;
            3'd2:    rem_adj = 4'd5;
            3'd3:    rem_adj = 4'd7;
            3'd4:    rem_adj = 4'd10;
            default: rem_adj = 4'd0;
        endcase
    end
    logic [31:0] ang;
    assign ang = 32'(r_q) * 32'd13 + {28'd0, rem_adj};
    logic signed [15:0] beat;
    assign beat = $signed(BeatTable[ang[31:24]]);
    logic signed [18:0] lsum;
    assign lsum = $signed({2'b0, tri_v}) + 19'(beat);

    // Shared multiplier
    logic signed [25:0] ma;
    logic signed [17:0] mb;
    logic signed [43:0] mp;
    assign mp = ma * mb;
    logic signed [24:0] px;
    assign px = $signed({r_x, 8'd0}) - r_pre;
    logic signed [24:0] pd;
    assign pd = 25'(r_acc) - r_post;
    logic signed [31:0] kex;
    assign kex = (r_post > 25'(KneeLevel)) ? 32'(r_post) - KneeLevel
                                          : -32'(r_post) - KneeLevel;
    always_comb begin
        ma = '0; mb = '0;
        case (r_state)
            S_PRE:  begin ma = 26'(px); mb = PreCoef; end
            S_DLY:  begin ma = $signed({9'd0, r_lfo}); mb = $signed({3'd0, sweep_half(r_mode)}); end
            S_RD1:  begin ma = 26'(r_s0); mb = $signed(18'(9'd256 - {1'b0, r_frac})); end
            S_INT:  begin ma = 26'(r_rd); mb = $signed({10'd0, r_frac}); end
            S_POST: begin ma = 26'(pd); mb = PostCoef; end
            S_KNEE: begin ma = 26'(kex); mb = KneeSlope; end
            default: ;
        endcase
    end

    logic signed [24:0] dly;
    logic signed [25:0] dly_raw;
    assign dly_raw = 26'(DlyCenter) - 26'(sweep_half(r_mode)) + 26'(mp >>> 15)
                   + (r_right ? 26'(RightOfs) : 26'd0);
    always_comb begin
        dly = 25'(dly_raw);
        if (dly_raw < 26'(DlyMin)) dly = DlyMin;
        if (dly_raw > 26'(DlyMax)) dly = DlyMax;
    end
    logic [15:0] pos;
    assign pos = {r_widx, 8'd0} - 16'(dly);

    logic signed [24:0] ktrunc;
    logic signed [31:0] kval;
    logic [AddrBits-1:0] rd_addr;
    assign rd_addr = (r_state == S_DLY) ? pos[15:8] : r_i0 + 8'd1;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr[AddrBits]) n_state = S_IDLE;
            S_IDLE: if (in_fire) n_state = (r_bypass || r_mode == ModeOff) ? S_PASS : S_PRE;
            S_PRE:  n_state = S_WR;
            S_WR:   n_state = S_LFO;
            S_LFO:  n_state = S_SUM;
            S_SUM:  n_state = S_DLY;
            S_DLY:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_INT;
            S_INT:  n_state = S_POST;
            S_POST: n_state = S_KNEE;
            S_KNEE: if (out_free) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            S_PASS: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_widx <= '0; r_phase <= '0;
            r_pre <= '0; r_post <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT || (r_state == S_PASS && out_free)) r_ovalid <= 1'b1;
            else if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_PRE: r_pre <= r_pre + 25'(mp >>> 15);
                S_POST: r_post <= r_post + 25'(mp >>> 15);
                S_OUT: begin
                    r_widx <= r_widx + 1'b1;
                    r_phase <= r_phase + phase_step(r_mode);
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) r_x <= s_in.sample;
        case (r_state)
            S_LFO: begin r_lfo <= tri_v; r_q <= q_prod[63:34]; end
            S_SUM: if (r_mode == ModeBeat)
                       r_lfo <= lsum < 0 ? 17'd0 : (lsum > 19'sd65536 ? 17'd65536 : 17'(lsum));
            S_DLY: begin r_i0 <= pos[15:8]; r_frac <= pos[7:0]; end
            S_RD0: r_s0 <= r_rd;
            S_RD1: r_acc <= 32'(mp);
            S_INT: r_acc <= r_acc + 32'(mp);
            S_KNEE: if (out_free)
                        r_out <= (kval > 32'sd8388607) ? 16'sd32767 :
                                 (kval < -32'sd8388607 ? -16'sd32768 : 16'(ktrunc >>> 8));
            S_PASS: if (out_free) r_out <= r_x;
            default: ;
        endcase
    end
    // Knee and truncation toward zero
    always_comb begin
        kval = 32'(r_post);
        if (r_post > 25'(KneeLevel)) kval = KneeLevel + 32'(mp >>> 15);
        else if (r_post < -25'(KneeLevel)) kval = -KneeLevel - 32'(mp >>> 15);
        ktrunc = 25'(kval) + ((kval < 0) ? 25'sd255 : 25'sd0);
        if (kval > 32'sd8388607 || kval < -32'sd8388607) ktrunc = '0;
    end

    // Delay memory: write pre level (trunc toward zero), sync read
    logic signed [24:0] pre_t;
    assign pre_t = (r_pre + ((r_pre < 0) ? 25'sd255 : 25'sd0)) >>> 8;
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR && !r_clr[AddrBits]) mem[r_clr[AddrBits-1:0]] <= '0;
        else if (r_state == S_WR) mem[r_widx] <= 16'(pre_t);
        r_rd <= mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_in.ready) else $error("accept while busy");
    a_out_after_knee: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> m_out.valid) else $error("result lost");
    a_widx_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |=> $stable(r_widx)) else $error("state moved in pass");
`endif
endmodule
`default_nettype wire

@@ tb/tb_stereo_chorus_voice.sv @@
// Testbench for the chorus voice: random and directed samples checked against a predictor.
module tb_stereo_chorus_voice;
    import scv_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scv_if s_in ();
    scv_if m_out ();

    stereo_chorus_voice dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in.sink),
        .m_out   (m_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and register copies
    logic [1:0]          cfg_mode;
    logic                cfg_bypass;
    logic                cfg_right;
    logic signed [15:0]  echo_mem [DelayDepth];
    logic [7:0]          wr_pos;
    logic [31:0]         sweep_phase;
    longint              pre_lvl;
    longint              post_lvl;
    longint              beat_lut [SineDepth];

    t_sample pending_samples [$];
    t_sample chorus_expected [$];
    int      cycle_count;
    int      out_count;
    int      hold_left;
    bit      hold_done;
    bit      failed;

    // Quarter-wave polynomial sine, Q30 output for a 32-bit angle
    function automatic longint poly_sin(input longint ang);
        longint q, q2, acc, res;
        q = ang & 64'h7FFF_FFFF;
        if (q > 64'sd1073741824) q = 64'sd2147483648 - q;
        q2 = (q * q) >>> 30;
        acc = 172272;
        acc = 5026995 - ((q2 * acc) >>> 30);
        acc = 85569306 - ((q2 * acc) >>> 30);
        acc = 693598668 - ((q2 * acc) >>> 30);
        acc = 1686629713 - ((q2 * acc) >>> 30);
        res = (q * acc) >>> 30;
        return ang[31] ? -res : res;
    endfunction

    function automatic longint toward_zero8(input longint v);
        return (v >= 0) ? (v >>> 8) : -((-v) >>> 8);
    endfunction

    // One sample through pre-filter, modulated delay, post-filter and knee, or returned as is in bypass or mode off
    function automatic t_sample chorus_predict(input t_sample x);
        logic [31:0]         p, tri_v, ang;
        longint              lfo, hr, dly, pos, frac, i0, i1, mix, y, o, depth;
        logic [63:0]         wide;
        if (cfg_bypass || cfg_mode == ModeOff) return x;
        pre_lvl += ((longint'(x) * 256 - pre_lvl) * 30244) >>> 15;
        echo_mem[wr_pos] = 16'(toward_zero8(pre_lvl));
        p = sweep_phase;
        if (cfg_right) p = p + 32'h8000_0000;
        tri_v = (p < 32'h8000_0000) ? (p >> 15) : 32'((64'h1_0000_0000 - p) >> 15);
        lfo = tri_v;
        if (cfg_mode == ModeBeat) begin
            wide = (64'(p) * 13) / 5;
            ang = wide[31:0];
            lfo = lfo + beat_lut[ang[31:24]];
            if (lfo < 0) lfo = 0;
            if (lfo > 65536) lfo = 65536;
        end
        case (cfg_mode)
            2'd1:    depth = 21299;
            2'd2:    depth = 29491;
            default: depth = 25559;
        endcase
        hr = (20838 * depth) >>> 15;
        dly = 39586 - hr + ((lfo * hr) >>> 15);
        if (cfg_right) dly += 1536;
        if (dly < 18748) dly = 18748;
        if (dly > 60424) dly = 60424;
        pos = (longint'(wr_pos) * 256 + 65536 - dly) % 65536;
        i0 = pos >> 8;
        frac = pos & 255;
        i1 = (i0 + 1) % 256;
        mix = longint'(echo_mem[i0]) * (256 - frac) + longint'(echo_mem[i1]) * frac;
        post_lvl += ((mix - post_lvl) * 20676) >>> 15;
        y = post_lvl;
        if (y > 4096000) y = 4096000 + (((y - 4096000) * 9830) >>> 15);
        else if (y < -4096000) y = -4096000 - (((-y - 4096000) * 9830) >>> 15);
        o = toward_zero8(y);
        if (o > 32767) o = 32767;
        if (o < -32768) o = -32768;
        wr_pos = wr_pos + 1;
        case (cfg_mode)
            2'd1:    sweep_phase = sweep_phase + 32'd48676;
            2'd2:    sweep_phase = sweep_phase + 32'd77882;
            default: sweep_phase = sweep_phase + 32'd63279;
        endcase
        return 16'(o);
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // No idling while this window of outputs passes
    wire calm = (out_count >= 500 && out_count < 800);

    // Driver: offers pending samples, predicts on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_in.valid <= 1'b0;
        end else begin
            if (s_in.valid && s_in.ready) begin
                chorus_expected.push_back(chorus_predict(s_in.sample));
                void'(pending_samples.pop_front());
            end
            if (s_in.valid && !s_in.ready) begin
                s_in.valid <= 1'b1;
            end else if (pending_samples.size() > 0 &&
                         (calm || $urandom_range(99) >= 21)) begin
                s_in.valid  <= 1'b1;
                s_in.sample <= pending_samples[0];
            end else begin
                s_in.valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls, one long hold-off, compares each output transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_out.ready <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                out_count <= out_count + 1;
                if (chorus_expected.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual %0d",
                             $realtime, m_out.sample);
                    failed = 1'b1;
                end else begin
                    if (m_out.sample !== chorus_expected[0]) begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $realtime, chorus_expected[0], m_out.sample);
                        failed = 1'b1;
                    end
                    void'(chorus_expected.pop_front());
                end
            end
            if (!hold_done && out_count == 300) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_out.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_out.ready <= 1'b0;
            end else begin
                m_out.ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Register write over the config port, predictor copy updated alongside
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegMode:   cfg_mode   = val[1:0];
            RegBypass: cfg_bypass = val[0];
            RegRight:  cfg_right  = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || chorus_expected.size() != 0 || s_in.valid)
            @(posedge i_clk);
    endtask

    // Random samples: full range, quiet, or a square tone of random amplitude
    task automatic queue_random(input int count);
        int     k, amp;
        longint tone;
        amp = $urandom_range(32767);
        for (k = 0; k < count; k++) begin
            case ($urandom_range(2))
                0: pending_samples.push_back(t_sample'($urandom));
                1: pending_samples.push_back(t_sample'($urandom_range(600) - 300));
                default: begin
                    tone = ((k % 64) < 32) ? amp : -amp - 1;
                    pending_samples.push_back(t_sample'(tone));
                end
            endcase
        end
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_in.valid = 1'b0;
        s_in.sample = '0;
        m_out.ready = 1'b0;
        cycle_count = 0;
        out_count = 0;
        hold_left = 0;
        hold_done = 1'b0;
        failed = 1'b0;
        cfg_mode = 2'd1;
        cfg_bypass = 1'b0;
        cfg_right = 1'b0;
        wr_pos = '0;
        sweep_phase = '0;
        pre_lvl = 0;
        post_lvl = 0;
        for (k = 0; k < DelayDepth; k++) echo_mem[k] = '0;
        for (k = 0; k < SineDepth; k++) begin
            longint s, m, e;
            s = poly_sin(longint'(k) << 24);
            m = (s < 0) ? -s : s;
            e = (m * 9830 + 536870912) >>> 30;
            beat_lut[k] = (s < 0) ? -e : e;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes in reset mode, then a run of full scale samples
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sd0);
        pending_samples.push_back(-16'sd1);
        for (k = 0; k < 8; k++) pending_samples.push_back(16'sh7FFF);
        wait_drained();
        // Bypass, mode off, and a write past the register list
        reg_write(RegBypass, 32'hFFFF_FFFF);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh1234);
        wait_drained();
        reg_write(RegBypass, 32'h0000_0002);
        reg_write(2'd3, 32'h0000_0000);
        reg_write(RegMode, 32'h0000_0004);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(-16'sd5);
        wait_drained();
        reg_write(RegMode, 32'hFFFF_FFFF);
        reg_write(RegRight, 32'h0000_0001);
        for (k = 0; k < 4; k++) pending_samples.push_back((k % 2) ? 16'sh8000 : 16'sh7FFF);
        wait_drained();

        // Random phases across settings
        for (k = 0; k < 8; k++) begin
            reg_write(RegMode, (k < 6) ? (k % 3) + 1 : $urandom_range(3));
            reg_write(RegRight, k % 2);
            reg_write(RegBypass, 32'(k == 7));
            queue_random(170);
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (!failed && chorus_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
